// ===== design/dser_pkg.sv =====
// ----------------------------------------------------------------------------
// dser_pkg: shared types and constants for the dual sonar echo ranger
// Event codes, command codes, register indexes and the pulse-to-cm converter.
// ----------------------------------------------------------------------------
package dser_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int LEN_WIDTH   = 16;
  localparam int DIST_WIDTH  = 8;
  localparam int CMD_WIDTH   = 8;
  localparam int CFG_IDX_W   = 8;

  localparam logic [LEN_WIDTH-1:0] TRIGGER_RESET = 16'd15;
  localparam logic [LEN_WIDTH-1:0] WAIT_RESET    = 16'd50000;

  // Echo pulse ticks per centimeter, and the reciprocal used to divide by it.
  localparam int CM_DIVISOR = 58;
  localparam int DIST_MAX   = 255;
  localparam int SAT_LIMIT  = (DIST_MAX + 1) * CM_DIVISOR;  // 14848
  localparam int RECIP_SH   = 20;
  localparam int RECIP_MUL  = ((1 << RECIP_SH) + CM_DIVISOR - 1) / CM_DIVISOR;
  localparam int QX_W       = 14;  // pulses below SAT_LIMIT fit here
  localparam int RECIP_W    = 15;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_LEFT  = 2'd1,
    MODE_RIGHT = 2'd2,
    MODE_CMD   = 2'd3
  } mode_e_t;

  localparam logic [CMD_WIDTH-1:0] CMD_RIGHT_DIST = 8'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_LEFT_DIST  = 8'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_LEN    = 8'd1;

  // pulse / 58, saturated at 255; reciprocal multiply is exact below SAT_LIMIT
  function automatic logic [DIST_WIDTH-1:0] to_cm(input logic [TIMER_WIDTH-1:0] pulse);
    logic [31:0]               wide;
    logic [QX_W+RECIP_W-1:0]   prod;
    wide = 32'(pulse);
    prod = (QX_W+RECIP_W)'(wide[QX_W-1:0]) * (QX_W+RECIP_W)'(RECIP_MUL);
    if (wide >= 32'(SAT_LIMIT)) begin
      return DIST_WIDTH'(DIST_MAX);
    end
    return prod[RECIP_SH +: DIST_WIDTH];
  endfunction

endpackage

// ===== design/dual_sonar_echo_ranger.sv =====
// ----------------------------------------------------------------------------
// dual_sonar_echo_ranger: two-channel ultrasonic ranger event processor
// Sequences left/right triggers on timer ticks, times echoes, answers queries.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready): one event per request. mode selects a
//   timebase tick, a left or right echo-line change, or a query byte carried
//   in command_byte (1 = right distance, 2 = left distance).
//   Output channel (out_valid/out_ready): exactly one result per request:
//   the trigger levels after the event, and reply_valid/reply_byte for a
//   query (reply_byte is 0 when no reply is given).
//   Config channel (cfg_valid/cfg_ready): cfg_index 0 writes trigger_length,
//   1 writes wait_length; other indexes are dropped. Always ready.
// Timing
//   The result is registered: a request accepted at edge N has its result
//   valid after edge N. Throughput is one request per cycle while out_ready
//   is high; the state update and the pulse-to-cm multiply sit between the
//   input handshake and the result register.
// Reset
//   Synchronous, active high. Lengths return to 15 and 50000, all timers,
//   flags and distances clear, sequencer starts in the left trigger phase.
// Stall
//   While a result waits (out_valid && !out_ready) no new request is taken;
//   in_ready follows out_ready as soon as the result register is occupied.
// ----------------------------------------------------------------------------
module dual_sonar_echo_ranger
  import dser_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // event requests
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            mode,
  input  logic [CMD_WIDTH-1:0]  command_byte,
  // results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  trigger_left,
  output logic                  trigger_right,
  output logic                  reply_valid,
  output logic [DIST_WIDTH-1:0] reply_byte,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [LEN_WIDTH-1:0]  cfg_data
);

  typedef enum logic [1:0] {
    PH_LEFT_TRIG  = 2'd0,
    PH_LEFT_WAIT  = 2'd1,
    PH_RIGHT_TRIG = 2'd2,
    PH_RIGHT_WAIT = 2'd3
  } phase_t;

  // configuration
  logic [LEN_WIDTH-1:0]   trigger_length;
  logic [LEN_WIDTH-1:0]   wait_length;

  // ranging state
  logic [TIMER_WIDTH-1:0] shared_timer, shared_timer_next;
  logic                   timer_running, timer_running_next;
  logic                   left_armed, left_armed_next;
  logic                   right_armed, right_armed_next;
  logic [TIMER_WIDTH-1:0] left_pulse, left_pulse_next;
  logic [TIMER_WIDTH-1:0] right_pulse, right_pulse_next;
  logic [DIST_WIDTH-1:0]  left_distance, left_distance_next;
  logic [DIST_WIDTH-1:0]  right_distance, right_distance_next;
  phase_t                 phase, phase_next;
  logic [LEN_WIDTH-1:0]   phase_ticks, phase_ticks_next;

  // per-event scratch
  logic                   accept;
  logic [LEN_WIDTH-1:0]   len_raw, len_eff, ticks_inc;
  logic                   phase_done;
  logic [TIMER_WIDTH-1:0] latch_pulse;
  logic [DIST_WIDTH-1:0]  latch_cm;
  logic                   rv_next;
  logic [DIST_WIDTH-1:0]  rb_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  // phase length; a zero length behaves like one tick
  assign len_raw    = phase[0] ? wait_length : trigger_length;
  assign len_eff    = (len_raw == '0) ? LEN_WIDTH'(1) : len_raw;
  assign ticks_inc  = phase_ticks + LEN_WIDTH'(1);
  // wrap of the tick counter also ends the phase
  assign phase_done = (ticks_inc >= len_eff) || (ticks_inc == '0);

  // only one wait phase latches per tick, so one converter serves both sides
  assign latch_pulse = (phase == PH_LEFT_WAIT) ? left_pulse : right_pulse;
  assign latch_cm    = to_cm(latch_pulse);

  always_comb begin
    shared_timer_next   = shared_timer;
    timer_running_next  = timer_running;
    left_armed_next     = left_armed;
    right_armed_next    = right_armed;
    left_pulse_next     = left_pulse;
    right_pulse_next    = right_pulse;
    left_distance_next  = left_distance;
    right_distance_next = right_distance;
    phase_next          = phase;
    phase_ticks_next    = phase_ticks;
    rv_next             = 1'b0;
    rb_next             = '0;

    unique case (mode_e_t'(mode))
      MODE_TICK: begin
        if (timer_running) begin
          shared_timer_next = shared_timer + TIMER_WIDTH'(1);
        end
        if (phase_done) begin
          phase_ticks_next = '0;
          unique case (phase)
            PH_LEFT_TRIG:  phase_next = PH_LEFT_WAIT;
            PH_LEFT_WAIT: begin
              left_distance_next = latch_cm;
              phase_next         = PH_RIGHT_TRIG;
            end
            PH_RIGHT_TRIG: phase_next = PH_RIGHT_WAIT;
            PH_RIGHT_WAIT: begin
              right_distance_next = latch_cm;
              phase_next          = PH_LEFT_TRIG;
            end
          endcase
        end else begin
          phase_ticks_next = ticks_inc;
        end
      end
      MODE_LEFT: begin
        // the timer is shared: a disarm on either side stops and clears it
        if (left_armed) begin
          timer_running_next = 1'b0;
          left_pulse_next    = shared_timer;
          shared_timer_next  = '0;
          left_armed_next    = 1'b0;
        end else begin
          timer_running_next = 1'b1;
          left_armed_next    = 1'b1;
        end
      end
      MODE_RIGHT: begin
        if (right_armed) begin
          timer_running_next = 1'b0;
          right_pulse_next   = shared_timer;
          shared_timer_next  = '0;
          right_armed_next   = 1'b0;
        end else begin
          timer_running_next = 1'b1;
          right_armed_next   = 1'b1;
        end
      end
      MODE_CMD: begin
        if (command_byte == CMD_RIGHT_DIST) begin
          rv_next = 1'b1;
          rb_next = right_distance;
        end else if (command_byte == CMD_LEFT_DIST) begin
          rv_next = 1'b1;
          rb_next = left_distance;
        end
      end
    endcase
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_length <= TRIGGER_RESET;
      wait_length    <= WAIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TRIGGER_LEN) begin
        trigger_length <= cfg_data;
      end else if (cfg_index == REG_WAIT_LEN) begin
        wait_length <= cfg_data;
      end
    end
  end

  // ranging state
  always_ff @(posedge clk) begin
    if (rst) begin
      shared_timer   <= '0;
      timer_running  <= 1'b0;
      left_armed     <= 1'b0;
      right_armed    <= 1'b0;
      left_pulse     <= '0;
      right_pulse    <= '0;
      left_distance  <= '0;
      right_distance <= '0;
      phase          <= PH_LEFT_TRIG;
      phase_ticks    <= '0;
    end else if (accept) begin
      shared_timer   <= shared_timer_next;
      timer_running  <= timer_running_next;
      left_armed     <= left_armed_next;
      right_armed    <= right_armed_next;
      left_pulse     <= left_pulse_next;
      right_pulse    <= right_pulse_next;
      left_distance  <= left_distance_next;
      right_distance <= right_distance_next;
      phase          <= phase_next;
      phase_ticks    <= phase_ticks_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      trigger_left  <= (phase_next == PH_LEFT_TRIG);
      trigger_right <= (phase_next == PH_RIGHT_TRIG);
      reply_valid   <= rv_next;
      reply_byte    <= rb_next;
    end
  end

endmodule

// ===== design/dser_checker.sv =====
// ----------------------------------------------------------------------------
// dser_checker: port-level checks for the dual sonar echo ranger
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module dser_checker
  import dser_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [1:0]            mode,
  input logic [CMD_WIDTH-1:0]  command_byte,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  trigger_left,
  input logic                  trigger_right,
  input logic                  reply_valid,
  input logic [DIST_WIDTH-1:0] reply_byte
);

  // nothing left over after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(reply_byte) && $stable(reply_valid))
    else $error("stalled result changed");

  // the sequencer never fires both triggers
  a_one_trigger: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(trigger_left && trigger_right))
    else $error("both triggers high");

  // no reply means a zero byte
  a_quiet_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reply_valid |-> reply_byte == '0)
    else $error("reply byte without reply");

  // result valid in the next cycle; only a known query gets a reply
  a_unknown_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (mode != 2'(MODE_CMD) ||
      (command_byte != CMD_RIGHT_DIST && command_byte != CMD_LEFT_DIST))
    |=> out_valid && !reply_valid)
    else $error("unexpected reply");

endmodule

bind dual_sonar_echo_ranger dser_checker u_dser_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .mode         (mode),
  .command_byte (command_byte),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .trigger_left (trigger_left),
  .trigger_right(trigger_right),
  .reply_valid  (reply_valid),
  .reply_byte   (reply_byte)
);

// ===== dv/dual_sonar_echo_ranger_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_sonar_echo_ranger_tb: self-checking bench for the two-channel ranger
// Sends tick, echo-edge and query requests under random stalls, predicts the
// trigger levels and replies with a cycle-free model, and checks every result.
// ----------------------------------------------------------------------------
module dual_sonar_echo_ranger_tb;
  import dser_pkg::*;

  // Sequencer phases: a tick advances left trigger -> left wait -> right
  // trigger -> right wait -> left trigger once the phase length is reached.
  typedef enum logic [1:0] {
    SEQ_LEFT_TRIG  = 2'd0,
    SEQ_LEFT_WAIT  = 2'd1,
    SEQ_RIGHT_TRIG = 2'd2,
    SEQ_RIGHT_WAIT = 2'd3
  } seq_phase_t;

  typedef struct packed {
    logic                  trig_l;
    logic                  trig_r;
    logic                  rep_v;
    logic [DIST_WIDTH-1:0] rep_b;
  } ranger_result_t;

  // One row of the directed table. Rows with pinned set carry a hand-written
  // result; the others are checked against the predictor.
  typedef struct {
    mode_e_t              mode;
    logic [CMD_WIDTH-1:0] cmd;
    logic                 pinned;
    ranger_result_t       want;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  mode_e_t               in_mode = MODE_TICK;
  logic [CMD_WIDTH-1:0]  in_cmd = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  trigger_left;
  logic                  trigger_right;
  logic                  reply_valid;
  logic [DIST_WIDTH-1:0] reply_byte;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [LEN_WIDTH-1:0]  cfg_data = '0;

  dual_sonar_echo_ranger u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (in_mode),
    .command_byte  (in_cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .trigger_left  (trigger_left),
    .trigger_right (trigger_right),
    .reply_valid   (reply_valid),
    .reply_byte    (reply_byte),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Ranger model state (mirrors the block's registers)
  // --------------------------------------------------------------------------
  logic [LEN_WIDTH-1:0]   trig_len;
  logic [LEN_WIDTH-1:0]   wait_len;
  logic [TIMER_WIDTH-1:0] echo_timer;
  logic                   echo_running;
  logic                   armed_left;
  logic                   armed_right;
  logic [TIMER_WIDTH-1:0] pulse_left;
  logic [TIMER_WIDTH-1:0] pulse_right;
  logic [DIST_WIDTH-1:0]  dist_left;
  logic [DIST_WIDTH-1:0]  dist_right;
  seq_phase_t             seq_phase;
  logic [15:0]            seq_ticks;

  ranger_result_t pending_results[$];  // predicted results, oldest first
  int             mismatches = 0;
  int             events_sent = 0;
  int             gap_pct = 0;         // chance in 100 that the sender idles
  int             stall_pct = 0;       // chance in 100 that the receiver stalls

  // Echo round trip in ticks to whole centimeters, clipped at the byte range.
  function automatic logic [DIST_WIDTH-1:0] pulse_to_cm(input logic [TIMER_WIDTH-1:0] ticks);
    int unsigned cm;
    cm = int'(ticks) / CM_DIVISOR;
    return (cm > DIST_MAX) ? DIST_WIDTH'(DIST_MAX) : DIST_WIDTH'(cm);
  endfunction

  // Applies one request to the model and returns the result it produces.
  function automatic ranger_result_t predict_event(input mode_e_t m,
                                                   input logic [CMD_WIDTH-1:0] c);
    ranger_result_t r;
    logic [LEN_WIDTH-1:0] span;
    r = '0;
    case (m)
      MODE_TICK: begin
        if (echo_running) echo_timer = echo_timer + 1'b1;
        span = seq_phase[0] ? wait_len : trig_len;
        if (span == '0) span = LEN_WIDTH'(1);  // zero length behaves as one tick
        seq_ticks = seq_ticks + 1'b1;
        // >= also covers a length lowered below the ticks already counted
        if (seq_ticks >= span || seq_ticks == '0) begin
          if (seq_phase == SEQ_LEFT_WAIT) dist_left = pulse_to_cm(pulse_left);
          else if (seq_phase == SEQ_RIGHT_WAIT) dist_right = pulse_to_cm(pulse_right);
          seq_phase = seq_phase_t'(seq_phase + 1'b1);
          seq_ticks = '0;
        end
      end
      // The timer is shared: a disarm on either channel stops and clears it,
      // even while the other channel is still armed.
      MODE_LEFT: begin
        if (armed_left) begin
          pulse_left   = echo_timer;
          echo_timer   = '0;
          echo_running = 1'b0;
          armed_left   = 1'b0;
        end else begin
          echo_running = 1'b1;
          armed_left   = 1'b1;
        end
      end
      MODE_RIGHT: begin
        if (armed_right) begin
          pulse_right  = echo_timer;
          echo_timer   = '0;
          echo_running = 1'b0;
          armed_right  = 1'b0;
        end else begin
          echo_running = 1'b1;
          armed_right  = 1'b1;
        end
      end
      default: begin
        if (c == CMD_RIGHT_DIST) begin
          r.rep_v = 1'b1;
          r.rep_b = dist_right;
        end else if (c == CMD_LEFT_DIST) begin
          r.rep_v = 1'b1;
          r.rep_b = dist_left;
        end
      end
    endcase
    r.trig_l = (seq_phase == SEQ_LEFT_TRIG);
    r.trig_r = (seq_phase == SEQ_RIGHT_TRIG);
    return r;
  endfunction

  function automatic void flag_mismatch(input string what, input ranger_result_t want,
                                        input ranger_result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected tl=%0b tr=%0b rv=%0b rb=%0d, got tl=%0b tr=%0b rv=%0b rb=%0d",
               $time, what, want.trig_l, want.trig_r, want.rep_v, want.rep_b,
               got.trig_l, got.trig_r, got.rep_v, got.rep_b);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random backpressure and in-order checking
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : result_check
    ranger_result_t got;
    ranger_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {trigger_left, trigger_right, reply_valid, reply_byte};
      if (pending_results.size() == 0) begin
        flag_mismatch("result with no request outstanding", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) flag_mismatch("result mismatch", want, got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Sends one request and, once taken, queues what it should produce. A pinned
  // request queues the hand-written result instead of the predicted one.
  task automatic send_event(input mode_e_t m, input logic [CMD_WIDTH-1:0] c,
                            input logic pin = 1'b0, input ranger_result_t pin_val = '0);
    ranger_result_t predicted;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= m;
    in_cmd   <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_event(m, c);
    pending_results.push_back(pin ? pin_val : predicted);
    events_sent++;
  endtask

  // Register write; only called with the block idle. Valid is left high so
  // back-to-back writes never drop and raise it within one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TRIGGER_LEN: trig_len = val;
      REG_WAIT_LEN:    wait_len = val;
      default: ;  // other indexes are dropped by the block
    endcase
  endtask

  // Stops sending and waits until every outstanding result is back, with a
  // bound in case the block hangs.
  task automatic wait_idle();
    int spin;
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    spin = 0;
    do begin
      @(posedge clk);
      spin++;
    end while (pending_results.size() != 0 && spin < 5000);
    repeat (2) @(posedge clk);
  endtask

  // Mostly full measurements (edge, ticks, edge, ticks through the latch,
  // both queries) with random content; the rest is stray requests.
  task automatic run_rounds(input int count);
    int      first;
    int      k;
    int      hold;
    mode_e_t ch;
    first = events_sent;
    while (events_sent - first < count) begin
      if ($urandom_range(99) < 70) begin
        ch = $urandom_range(1) ? MODE_LEFT : MODE_RIGHT;
        send_event(ch, 8'($urandom));
        hold = ($urandom_range(99) < 70) ? $urandom_range(40) : $urandom_range(58, 600);
        for (k = 0; k < hold; k++) begin
          // occasional stray edge or query; a stray edge can break the measurement
          if ($urandom_range(99) < 3) send_event(mode_e_t'($urandom_range(1, 3)), 8'($urandom));
          send_event(MODE_TICK, 8'($urandom));
        end
        send_event(ch, 8'($urandom));
        hold = $urandom_range(2 * (int'(trig_len) + int'(wait_len)) + 4);
        for (k = 0; k < hold; k++) send_event(MODE_TICK, 8'($urandom));
        if ($urandom_range(1)) begin
          send_event(MODE_CMD, CMD_LEFT_DIST);
          send_event(MODE_CMD, CMD_RIGHT_DIST);
        end else begin
          send_event(MODE_CMD, CMD_RIGHT_DIST);
          send_event(MODE_CMD, CMD_LEFT_DIST);
        end
      end else begin
        repeat ($urandom_range(1, 4)) send_event(mode_e_t'($urandom_range(3)), 8'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table: queries straight after reset, unknown command bytes, and
  // the shared timer stopped by one channel while the other is armed.
  // --------------------------------------------------------------------------
  dir_row_t dir_rows [14];

  // Rounding boundaries: just below and at one and two centimeters.
  int unsigned long_pulses [4] = '{57, 58, 115, 116};

  initial begin : stimulus
    int i;
    int k;
    dir_rows = '{
      '{MODE_CMD,   8'd1,   1'b1, '{1'b1, 1'b0, 1'b1, 8'd0}},  // reset distances
      '{MODE_CMD,   8'd2,   1'b1, '{1'b1, 1'b0, 1'b1, 8'd0}},
      '{MODE_CMD,   8'd0,   1'b1, '{1'b1, 1'b0, 1'b0, 8'd0}},  // unknown bytes
      '{MODE_CMD,   8'd255, 1'b1, '{1'b1, 1'b0, 1'b0, 8'd0}},
      '{MODE_CMD,   8'd3,   1'b1, '{1'b1, 1'b0, 1'b0, 8'd0}},
      '{MODE_LEFT,  8'hAA,  1'b1, '{1'b1, 1'b0, 1'b0, 8'd0}},  // left arms, timer runs
      '{MODE_TICK,  8'h55,  1'b0, '0},
      '{MODE_RIGHT, 8'h00,  1'b0, '0},                          // right arms too
      '{MODE_TICK,  8'hFF,  1'b0, '0},
      '{MODE_RIGHT, 8'h00,  1'b0, '0},                          // right stops shared timer
      '{MODE_TICK,  8'h00,  1'b0, '0},
      '{MODE_LEFT,  8'h00,  1'b0, '0},                          // left captures cleared count
      '{MODE_CMD,   8'd1,   1'b1, '{1'b1, 1'b0, 1'b1, 8'd0}},  // nothing latched yet
      '{MODE_TICK,  8'h01,  1'b0, '0}
    };

    // model reset values
    trig_len     = TRIGGER_RESET;
    wait_len     = WAIT_RESET;
    echo_timer   = '0;
    echo_running = 1'b0;
    armed_left   = 1'b0;
    armed_right  = 1'b0;
    pulse_left   = '0;
    pulse_right  = '0;
    dist_left    = '0;
    dist_right   = '0;
    seq_phase    = SEQ_LEFT_TRIG;
    seq_ticks    = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Phase 1: sender seldom idles, receiver mostly stalls.
    gap_pct   = 16;
    stall_pct = 74;
    for (i = 0; i < 14; i++) begin
      send_event(dir_rows[i].mode, dir_rows[i].cmd, dir_rows[i].pinned, dir_rows[i].want);
    end

    // Maximum lengths, then a trigger length lowered below the ticks already
    // counted: the phase must end on the very next tick.
    wait_idle();
    write_reg(REG_TRIGGER_LEN, 16'hFFFF);
    write_reg(REG_WAIT_LEN, 16'hFFFF);
    repeat (6) send_event(MODE_TICK, 8'($urandom));
    wait_idle();
    write_reg(REG_TRIGGER_LEN, 16'd2);
    send_event(MODE_TICK, 8'h00);
    // zero wait length acts as one tick; out-of-range indexes change nothing
    wait_idle();
    write_reg(REG_WAIT_LEN, 16'd0);
    write_reg(8'd2, 16'd7);
    write_reg(8'hFF, 16'd7);
    repeat (3) send_event(MODE_TICK, 8'($urandom));
    send_event(MODE_CMD, CMD_LEFT_DIST);
    send_event(MODE_CMD, CMD_RIGHT_DIST);

    wait_idle();
    write_reg(REG_TRIGGER_LEN, 16'($urandom_range(1, 4)));
    write_reg(REG_WAIT_LEN, 16'($urandom_range(1, 12)));
    run_rounds(120);

    // Phase 2: sender mostly idles, receiver seldom stalls.
    wait_idle();
    gap_pct   = 74;
    stall_pct = 16;
    write_reg(REG_TRIGGER_LEN, 16'd0);
    write_reg(REG_WAIT_LEN, 16'($urandom_range(0, 6)));
    run_rounds(60);
    wait_idle();
    write_reg(REG_TRIGGER_LEN, 16'($urandom_range(2, 9)));
    write_reg(REG_WAIT_LEN, 16'($urandom_range(5, 30)));
    run_rounds(60);

    // Phase 3: no idling. Echoes at the rounding boundaries with the sequencer
    // spinning every tick, so each capture is latched a few ticks later.
    wait_idle();
    gap_pct   = 0;
    stall_pct = 0;
    write_reg(REG_TRIGGER_LEN, 16'd1);
    write_reg(REG_WAIT_LEN, 16'd1);
    for (i = 0; i < 4; i++) begin
      if (i[0] == 1'b0) begin
        if (armed_left) send_event(MODE_LEFT, 8'h00);
        send_event(MODE_LEFT, 8'h00);
        for (k = 0; k < int'(long_pulses[i]); k++) send_event(MODE_TICK, 8'($urandom));
        send_event(MODE_LEFT, 8'h00);
      end else begin
        if (armed_right) send_event(MODE_RIGHT, 8'h00);
        send_event(MODE_RIGHT, 8'h00);
        for (k = 0; k < int'(long_pulses[i]); k++) send_event(MODE_TICK, 8'($urandom));
        send_event(MODE_RIGHT, 8'h00);
      end
      repeat (4) send_event(MODE_TICK, 8'($urandom));
      send_event(MODE_CMD, CMD_LEFT_DIST);
      send_event(MODE_CMD, CMD_RIGHT_DIST);
    end
    wait_idle();
    write_reg(REG_TRIGGER_LEN, 16'($urandom_range(1, 3)));
    write_reg(REG_WAIT_LEN, 16'($urandom_range(1, 3)));
    run_rounds(100);

    wait_idle();
    if (pending_results.size() != 0) begin
      flag_mismatch("result never arrived", pending_results[0], '0);
    end
    if (mismatches == 0) begin
      $display("dual_sonar_echo_ranger_tb: clean");
    end else begin
      $display("dual_sonar_echo_ranger_tb: errors");
    end
    $finish;
  end

  // Hang guard: ends the run if the stimulus never finishes.
  initial begin
    #10_000_000;
    $display("dual_sonar_echo_ranger_tb: errors");
    $finish;
  end

endmodule
